// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/bb_pkg.sv
// ----------------------------------------------------------------------------
// bb_pkg
// Shared constants and controller/datapath interface types of the box blur.
// ----------------------------------------------------------------------------
package bb_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;

    localparam int PIX_W  = 24;
    localparam int QBITS  = 8;
    localparam int STEP_W = 3;

    typedef struct packed {
        logic capture;
        logic commit;
        logic div_step;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic work;
        logic emit;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/bb_ctrl.sv
// ----------------------------------------------------------------------------
// bb_ctrl
// Sequencer: capture, line read, window commit, divide, result load.
// ----------------------------------------------------------------------------
module bb_ctrl (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  bb_pkg::sts_t sts,
    output bb_pkg::cmd_t cmd
);
    import bb_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_COMMIT = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_LOAD   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && sts.work) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = sts.emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/bb_datapath.sv
// ----------------------------------------------------------------------------
// bb_datapath
// Line memory, 3x3 window, raster counters, neighbourhood sum and divider.
// ----------------------------------------------------------------------------
module bb_datapath #(
    parameter int MAX_WIDTH = bb_pkg::MAX_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bb_pkg::cmd_t                  cmd,
    output bb_pkg::sts_t                  sts,
    input  logic                          cfg_we,
    input  logic [bb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          s_action,
    input  logic [7:0]                    s_red_in,
    input  logic [7:0]                    s_green_in,
    input  logic [7:0]                    s_blue_in,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [7:0]                    m_red_out,
    output logic [7:0]                    m_green_out,
    output logic [7:0]                    m_blue_out,
    output logic                          m_frame_end
);
    import bb_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW    = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;

    logic [10:0]        fw_reg;
    logic [11:0]        fh_reg;
    logic [COL_W-1:0]   in_col_reg;
    logic [12:0]        in_row_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [11:0]        out_row_reg;

    logic               action_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [COL_W-1:0]   col_reg;
    logic [2*PIX_W-1:0] line_rd_reg;
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [PIX_W-1:0]   win_reg [3][2];

    logic [12:0]        rem_reg [3];
    logic [QBITS-1:0]   q_reg [3];
    logic [4:0]         den_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               fe_reg;

    logic               m_valid_reg;
    logic [7:0]         red_reg;
    logic [7:0]         green_reg;
    logic [7:0]         blue_reg;
    logic               frame_end_reg;

    logic [EW-1:0]      eff_w;
    logic [11:0]        eff_h;
    logic               draining;
    logic [COL_W-1:0]   c_cur;
    logic               emit;
    logic               left, right, up, down;
    logic [PIX_W-1:0]   new_col [3];
    logic [11:0]        sum [3];
    logic [1:0]         ncols, nrows;
    logic [3:0]         count;
    logic               fe;
    logic [EW-1:0]      in_col_inc;
    logic [11:0]        trial;

    always_comb begin
        if (fw_reg == 11'd0) begin
            eff_w = EW'(1);
        end else if (EW'(fw_reg) > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(fw_reg);
        end
    end

    assign eff_h    = (fh_reg == 12'd0) ? 12'd1 : fh_reg;
    assign draining = in_row_reg >= {1'b0, eff_h};
    assign c_cur    = (EW'(in_col_reg) >= eff_w) ? '0 : in_col_reg;

    assign emit  = (in_row_reg >= 13'd2) || ((in_row_reg == 13'd1) && (col_reg != '0));
    assign left  = out_col_reg != '0;
    assign right = col_reg != '0;
    assign up    = out_row_reg != 12'd0;
    assign down  = (13'(out_row_reg) + 13'd1) < 13'(eff_h);
    assign fe    = ((13'(out_row_reg) + 13'd1) >= 13'(eff_h))
                && ((EW'(out_col_reg) + EW'(1)) >= eff_w);
    assign in_col_inc = EW'(col_reg) + EW'(1);

    assign new_col[0] = line_rd_reg[2*PIX_W-1:PIX_W];
    assign new_col[1] = line_rd_reg[PIX_W-1:0];
    assign new_col[2] = pix_reg;

    assign ncols = 2'd1 + {1'b0, left} + {1'b0, right};
    assign nrows = 2'd1 + {1'b0, up} + {1'b0, down};
    assign count = 4'(ncols) * 4'(nrows);

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
            for (int r = 0; r < 3; r++) begin
                if ((r == 1) || (r == 0 && up) || (r == 2 && down)) begin
                    if (left) begin
                        sum[ch] = sum[ch] + 12'(win_reg[r][0][16-8*ch +: 8]);
                    end
                    sum[ch] = sum[ch] + 12'(win_reg[r][1][16-8*ch +: 8]);
                    if (right) begin
                        sum[ch] = sum[ch] + 12'(new_col[r][16-8*ch +: 8]);
                    end
                end
            end
        end
    end

    assign trial = 12'(den_reg) << step_reg;

    // line memory: {older, newer} per column
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            line_rd_reg <= line_mem[c_cur];
        end
        if (cmd.commit) begin
            line_mem[col_reg] <= {line_rd_reg[PIX_W-1:0], pix_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= s_action;
            pix_reg    <= s_action ? '0 : {s_red_in, s_green_in, s_blue_in};
            col_reg    <= c_cur;
        end
        if (cmd.commit) begin
            for (int ch = 0; ch < 3; ch++) begin
                rem_reg[ch] <= {sum[ch], 1'b0} + 13'(count);
                q_reg[ch]   <= '0;
            end
            den_reg  <= {count, 1'b0};
            step_reg <= STEP_W'(QBITS - 1);
            fe_reg   <= fe;
        end else if (cmd.div_step) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (rem_reg[ch] >= {1'b0, trial}) begin
                    rem_reg[ch]          <= rem_reg[ch] - {1'b0, trial};
                    q_reg[ch][step_reg]  <= 1'b1;
                end
            end
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= '0;
                win_reg[r][1] <= '0;
            end
        end else if (cmd.commit) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= new_col[r];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg      <= FRAME_WIDTH_RST;
            fh_reg      <= FRAME_HEIGHT_RST;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == REG_FRAME_WIDTH) begin
                fw_reg <= cfg_data[10:0];
            end
            if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            if (cfg_index == REG_FRAME_HEIGHT) begin
                fh_reg <= cfg_data;
            end
        end else if (cmd.commit) begin
            if (emit && fe) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end else begin
                if (in_col_inc >= eff_w) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + 13'd1;
                end else begin
                    in_col_reg <= in_col_inc[COL_W-1:0];
                end
                if (emit) begin
                    if ((EW'(out_col_reg) + EW'(1)) >= eff_w) begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + 12'd1;
                    end else begin
                        out_col_reg <= out_col_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            red_reg       <= q_reg[0];
            green_reg     <= q_reg[1];
            blue_reg      <= q_reg[2];
            frame_end_reg <= fe_reg;
        end
    end

    assign sts.work     = (s_action == draining);
    assign sts.emit     = emit && !action_reg || emit;
    assign sts.div_last = step_reg == '0;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_red_out   = red_reg;
    assign m_green_out = green_reg;
    assign m_blue_out  = blue_reg;
    assign m_frame_end = frame_end_reg;

endmodule

// File: rtl/box_blur_3x3.sv
// ----------------------------------------------------------------------------
// box_blur_3x3
// Streaming 3x3 RGB box blur with in-frame rounded mean per channel.
// ----------------------------------------------------------------------------
// channel   handshake          payload
// s_        s_valid/s_ready    s_action, s_red_in, s_green_in, s_blue_in
// m_        m_valid/m_ready    m_red_out, m_green_out, m_blue_out, m_frame_end
// cfg_      cfg_valid/ready    cfg_index, cfg_data
//
// A beat that yields a result passes through capture, line memory read,
// window commit, eight steps of the restoring divider and result load.
// A beat with no result ends at the window commit; a dropped beat is not captured.
// Reset is synchronous, active low; the line memory is not cleared.
// A result waiting on m_ready holds the load step only; the slot frees as it leaves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module box_blur_3x3 #(
    parameter int MAX_WIDTH = bb_pkg::MAX_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [7:0]                    s_red_in,
    input  logic [7:0]                    s_green_in,
    input  logic [7:0]                    s_blue_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_red_out,
    output logic [7:0]                    m_green_out,
    output logic [7:0]                    m_blue_out,
    output logic                          m_frame_end
);
    import bb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    bb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bb_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_action    (s_action),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_frame_end (m_frame_end)
    );

    `BB_ASSERT_IMPL(a_load_free, aclk, aresetn, cmd.load, sts.out_free)
    `BB_ASSERT_NEXT(a_capture_busy, aclk, aresetn, cmd.capture, !s_ready)
    `BB_ASSERT_IMPL(a_one_cmd, aclk, aresetn, 1'b1, $onehot0(cmd))
    `BB_ASSERT_NEXT(a_load_valid, aclk, aresetn, cmd.load, m_valid)

endmodule

// File: dv/tb_box_blur_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3
// Self-checking bench for the streaming 3x3 box blur. A short table of
// beats runs first, then random frames of small sizes, with noise beats and
// cut-short frames, then a few frames with out-of-range sizes. Results are
// checked against a behavioral blur in the bench, or the table's value
// where given, under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3;
    import bb_pkg::*;

    localparam int LINE_DEPTH = 1024;
    localparam int IDLE_LIMIT = 5000;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       fend;
    } blur_pix_t;

    typedef struct {
        bit          flush;
        logic [23:0] rgb;
        bit          known;
        logic [23:0] want;
    } beat_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_action = 1'b0;
    logic [7:0]            s_red_in = '0;
    logic [7:0]            s_green_in = '0;
    logic [7:0]            s_blue_in = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [7:0]            m_red_out;
    logic [7:0]            m_green_out;
    logic [7:0]            m_blue_out;
    logic                  m_frame_end;

    box_blur_3x3 dut (.*);

    always #5 aclk = ~aclk;

    // behavioral blur state
    int unsigned width_reg = 640;
    int unsigned height_reg = 480;
    logic [23:0] older_line [LINE_DEPTH];
    logic [23:0] newer_line [LINE_DEPTH];
    logic [23:0] win [9];
    int unsigned in_col, in_row, out_col, out_row;

    blur_pix_t   blurred_q[$];
    int          errors = 0;
    int          beats_sent = 0;
    int          s_idle_pct = 0;
    int          m_stall_pct = 0;
    bit          hold_go = 0;
    int          hold_cnt = 0;
    int          idle_cycles = 0;

    function automatic int unsigned eff_w();
        if (width_reg < 1) return 1;
        if (width_reg > LINE_DEPTH) return LINE_DEPTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_h();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function automatic void restart_positions();
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    endfunction

    function automatic logic [23:0] neighbour_mean(int unsigned mid, bit lf, bit rt,
                                                   bit up, bit dn);
        int unsigned sum [3];
        int unsigned cnt;
        int unsigned slot;
        int unsigned v;
        logic [23:0] px;
        logic [23:0] res;
        sum = '{0, 0, 0};
        cnt = 0;
        res = '0;
        for (int r = 0; r < 3; r++) begin
            if ((r == 0 && !up) || (r == 2 && !dn)) continue;
            for (int k = 0; k < 3; k++) begin
                if (k == 0) begin
                    if (!lf || mid == 0) continue;
                    slot = mid - 1;
                end else if (k == 1) begin
                    slot = mid;
                end else begin
                    if (!rt || mid >= 2) continue;
                    slot = mid + 1;
                end
                px = win[(r * 3 + slot) % 9];
                sum[0] += px[23:16];
                sum[1] += px[15:8];
                sum[2] += px[7:0];
                cnt++;
            end
        end
        if (cnt == 0) cnt = 1;
        for (int ch = 0; ch < 3; ch++) begin
            v = (2 * sum[ch] + cnt) / (2 * cnt);
            if (v > 255) v = 255;
            res[23 - 8 * ch -: 8] = v[7:0];
        end
        return res;
    endfunction

    function automatic bit blur_step(bit flush, logic [23:0] rgb, output blur_pix_t res);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        bit          emit;
        logic [23:0] pix;
        logic [23:0] mean;
        w = eff_w();
        h = eff_h();
        mean = '0;
        res = '{default: '0};
        if (flush != (in_row >= h)) return 0;
        pix = flush ? 24'h0 : rgb;
        c = (in_col >= w) ? 0 : in_col;
        emit = in_row >= 2 || (in_row == 1 && c >= 1);
        if (emit && c == 0)
            mean = neighbour_mean(2, out_col >= 1, 0, out_row >= 1, out_row + 1 < h);
        for (int r = 0; r < 3; r++) begin
            win[r * 3] = win[r * 3 + 1];
            win[r * 3 + 1] = win[r * 3 + 2];
        end
        win[2] = older_line[c];
        win[5] = newer_line[c];
        win[8] = pix;
        older_line[c] = newer_line[c];
        newer_line[c] = pix;
        if (emit && c != 0)
            mean = neighbour_mean(1, out_col >= 1, 1, out_row >= 1, out_row + 1 < h);
        c++;
        if (c >= w) begin
            c = 0;
            in_row++;
        end
        in_col = c;
        if (!emit) return 0;
        res.red = mean[23:16];
        res.green = mean[15:8];
        res.blue = mean[7:0];
        if (out_row + 1 >= h && out_col + 1 >= w) begin
            res.fend = 1'b1;
            restart_positions();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        return 1;
    endfunction

    // entered and left at a falling edge
    task automatic send_beat(bit flush, logic [23:0] rgb, bit known = 0,
                             logic [23:0] want = '0);
        blur_pix_t res;
        while ($urandom_range(99) < s_idle_pct) @(negedge aclk);
        s_valid = 1'b1;
        s_action = flush;
        {s_red_in, s_green_in, s_blue_in} = rgb;
        do @(posedge aclk); while (!s_ready);
        if (blur_step(flush, rgb, res)) begin
            if (known) {res.red, res.green, res.blue} = want;
            blurred_q.push_back(res);
        end
        beats_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait (blurred_q.size() == 0);
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_FRAME_WIDTH) width_reg = val[10:0];
        else height_reg = val[11:0];
        restart_positions();
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_frame(int unsigned w, int unsigned h, int noise_pct);
        int unsigned ew;
        int unsigned eh;
        int unsigned cut;
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
        ew = eff_w();
        eh = eff_h();
        cut = ($urandom_range(9) == 0) ? $urandom_range(ew * eh - 1) : ew * eh;
        for (int unsigned i = 0; i < ew * eh; i++) begin
            if ($urandom_range(99) < noise_pct) send_beat(1, 24'($urandom));
            if (i == cut) return;
            send_beat(0, 24'($urandom));
        end
        for (int unsigned i = 0; i <= ew; i++) begin
            if ($urandom_range(99) < noise_pct) send_beat(0, 24'($urandom));
            send_beat(1, 24'($urandom));
        end
    endtask

    // receiver
    always @(negedge aclk) begin
        if (hold_go) begin
            hold_go = 0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready = 1'b0;
        end else begin
            m_ready = ($urandom_range(99) >= m_stall_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        blur_pix_t exp_pix;
        if (aresetn && m_valid && m_ready) begin
            if (blurred_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h %h %h fe=%b",
                                           m_red_out, m_green_out, m_blue_out, m_frame_end);
            end else begin
                exp_pix = blurred_q.pop_front();
                if (m_red_out !== exp_pix.red || m_green_out !== exp_pix.green ||
                    m_blue_out !== exp_pix.blue || m_frame_end !== exp_pix.fend) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %h %h %h fe=%b got %h %h %h fe=%b",
                                 exp_pix.red, exp_pix.green, exp_pix.blue, exp_pix.fend,
                                 m_red_out, m_green_out, m_blue_out, m_frame_end);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        beat_row_t tbl [$];
        for (int i = 0; i < LINE_DEPTH; i++) begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        restart_positions();

        tbl = '{
            '{1, 24'h123456, 0, 0},
            '{0, 24'hFFFFFF, 0, 0}, '{0, 24'hFFFFFF, 0, 0},
            '{0, 24'hFFFFFF, 0, 0}, '{0, 24'hFFFFFF, 1, 24'hFFFFFF},
            '{0, 24'hABCDEF, 0, 0},
            '{1, 0, 1, 24'hFFFFFF}, '{1, 0, 1, 24'hFFFFFF}, '{1, 0, 1, 24'hFFFFFF},
            '{0, 24'h00FF80, 0, 0}, '{0, 24'hFF0001, 0, 0},
            '{0, 24'h7F80FE, 0, 0}, '{0, 24'h01FE00, 0, 0},
            '{1, 0, 0, 0}, '{1, 0, 0, 0}, '{1, 0, 0, 0},
            '{0, 24'h000000, 0, 0}, '{0, 24'h000000, 0, 0},
            '{0, 24'h000000, 0, 0}, '{0, 24'h000000, 1, 24'h000000},
            '{1, 0, 1, 24'h000000}, '{1, 0, 1, 24'h000000}, '{1, 0, 1, 24'h000000}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(2));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
        foreach (tbl[i]) send_beat(tbl[i].flush, tbl[i].rgb, tbl[i].known, tbl[i].want);

        for (int ph = 0; ph < 4; ph++) begin
            s_idle_pct = (ph == 1) ? 62 : (ph == 3) ? 11 : 0;
            m_stall_pct = (ph == 2) ? 62 : (ph == 3) ? 11 : 0;
            if (ph == 2) hold_go = 1;
            while (beats_sent < 25 + (ph + 1) * 175) begin
                if ($urandom_range(7) == 0)
                    run_frame($urandom_range(1, 40), $urandom_range(1, 8), 10);
                else
                    run_frame($urandom_range(1, 6), $urandom_range(1, 6), 10);
            end
        end

        s_idle_pct = 0;
        m_stall_pct = 11;
        run_frame(12'h800, 3, 0);
        run_frame(0, 0, 0);
        run_frame(3, 12'h000, 0);

        wait (blurred_q.size() == 0);
        repeat (40) @(posedge aclk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
